>>> hw/rtl/b64c_pkg.sv
// Shared types, constants and alphabet functions for the base64 stream codec.
`timescale 1ns / 1ps

package b64c_pkg;

   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   localparam logic [7:0] PAD_CHAR   = 8'h3D;  // '='
   localparam logic [7:0] PLUS_CHAR  = 8'h2B;  // '+'
   localparam logic [7:0] SLASH_CHAR = 8'h2F;  // '/'

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       bad_input;
   } rsp_type;

   // One finished group handed from front to back.
   typedef struct packed {
      logic        mode;     // MODE_ENCODE or MODE_DECODE
      logic        last;     // group closes the stream
      logic        bad;      // bad_input on every result of the group
      logic [1:0]  enc_cnt;  // encode: bytes in group; chars 0..enc_cnt carry data
      logic [1:0]  cnt_m1;   // number of results minus one
      logic [23:0] bits;     // group bits, MSB first
   } job_type;

   // Sextet to alphabet character.
   function automatic logic [7:0] sextet_char(input logic [5:0] s);
      logic [7:0] c;
      if (s < 6'd26) begin
         c = 8'h41 + {2'b00, s};
      end else if (s < 6'd52) begin
         c = 8'h61 + {2'b00, s - 6'd26};
      end else if (s < 6'd62) begin
         c = 8'h30 + {2'b00, s - 6'd52};
      end else if (s == 6'd62) begin
         c = PLUS_CHAR;
      end else begin
         c = SLASH_CHAR;
      end
      return c;
   endfunction

   // Character to {invalid, sextet}; invalid characters give sextet zero.
   function automatic logic [6:0] char_sextet(input logic [7:0] c);
      logic [6:0] r;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = {1'b0, 6'(c - 8'h41)};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         r = {1'b0, 6'(c - 8'h61 + 8'd26)};
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b0, 6'(c - 8'h30 + 8'd52)};
      end else if (c == PLUS_CHAR) begin
         r = {1'b0, 6'd62};
      end else if (c == SLASH_CHAR) begin
         r = {1'b0, 6'd63};
      end else begin
         r = {1'b1, 6'd0};
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/b64c_front.sv
// Front end: mode register, input acceptance and group assembly.
`timescale 1ns / 1ps

module b64c_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic              csr_wdata,
   input  logic              req_valid,
   output logic              req_stall,
   input  b64c_pkg::req_type req_payload,
   input  logic              q_full,
   output logic              q_push,
   output b64c_pkg::job_type q_data
);
   import b64c_pkg::*;

   logic        mode_ff, mode_in;
   logic [1:0]  count_ff, count_in;
   logic [23:0] bits_ff, bits_in;
   logic        third_pad_ff, third_pad_in;
   logic        bad_ff, bad_in;

   logic        accept;
   logic        pad;
   logic [6:0]  lookup;
   logic [5:0]  sx;
   logic        bad_now;
   logic [23:0] bits_new;
   logic [2:0]  enc_next;
   logic [1:0]  dec_n_m1;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   assign pad     = (req_payload.in_byte == PAD_CHAR);
   assign lookup  = char_sextet(req_payload.in_byte);
   assign sx      = (pad || lookup[6]) ? 6'd0 : lookup[5:0];
   assign bad_now = bad_ff || (!pad && lookup[6]);
   assign enc_next = {1'b0, count_ff} + 3'd1;

   always_comb begin
      bits_new = bits_ff;
      if (mode_ff == MODE_ENCODE) begin
         case (count_ff)
            2'd0:    bits_new[23:16] = req_payload.in_byte;
            2'd1:    bits_new[15:8]  = req_payload.in_byte;
            default: bits_new[7:0]   = req_payload.in_byte;
         endcase
      end else begin
         case (count_ff)
            2'd0:    bits_new[23:18] = sx;
            2'd1:    bits_new[17:12] = sx;
            2'd2:    bits_new[11:6]  = sx;
            default: bits_new[5:0]   = sx;
         endcase
      end
   end

   // Final group: each '=' in the last two places drops one byte.
   always_comb begin
      dec_n_m1 = 2'd2;
      if (req_payload.in_last) begin
         dec_n_m1 = 2'd2 - {1'b0, pad} - {1'b0, third_pad_ff};
      end
   end

   always_comb begin
      mode_in      = mode_ff;
      count_in     = count_ff;
      bits_in      = bits_ff;
      third_pad_in = third_pad_ff;
      bad_in       = bad_ff;
      q_push       = 1'b0;
      q_data       = '0;
      q_data.mode  = mode_ff;
      q_data.last  = req_payload.in_last;
      if (csr_we) begin
         mode_in      = csr_wdata;
         count_in     = 2'd0;
         bits_in      = '0;
         third_pad_in = 1'b0;
         bad_in       = 1'b0;
      end else if (accept) begin
         if (mode_ff == MODE_ENCODE) begin
            if (enc_next == 3'd3 || req_payload.in_last) begin
               q_push         = 1'b1;
               q_data.bits    = bits_new;
               q_data.cnt_m1  = 2'd3;
               q_data.enc_cnt = enc_next[1:0];
               count_in       = 2'd0;
               bits_in        = '0;
            end else begin
               count_in = enc_next[1:0];
               bits_in  = bits_new;
            end
         end else begin
            if (count_ff != 2'd3) begin
               if (req_payload.in_last) begin
                  // length error: one zero byte flagged bad
                  q_push        = 1'b1;
                  q_data.bad    = 1'b1;
                  q_data.cnt_m1 = 2'd0;
                  count_in      = 2'd0;
                  bits_in       = '0;
                  third_pad_in  = 1'b0;
                  bad_in        = 1'b0;
               end else begin
                  count_in = count_ff + 2'd1;
                  bits_in  = bits_new;
                  bad_in   = bad_now;
                  if (count_ff == 2'd2) begin
                     third_pad_in = pad;
                  end
               end
            end else begin
               q_push        = 1'b1;
               q_data.bits   = bits_new;
               q_data.bad    = bad_now;
               q_data.cnt_m1 = dec_n_m1;
               count_in      = 2'd0;
               bits_in       = '0;
               third_pad_in  = 1'b0;
               bad_in        = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_ENCODE;
         count_ff     <= 2'd0;
         bits_ff      <= '0;
         third_pad_ff <= 1'b0;
         bad_ff       <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         bits_ff      <= bits_in;
         third_pad_ff <= third_pad_in;
         bad_ff       <= bad_in;
      end
   end

endmodule

>>> hw/rtl/b64c_fifo.sv
// Small group queue between front and back.
`timescale 1ns / 1ps

module b64c_fifo #(
   parameter int DEPTH = b64c_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  b64c_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              q_valid,
   output b64c_pkg::job_type pop_data
);
   import b64c_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign q_valid  = (count_ff != '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop)) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_valid) else $error("queue underflow");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH)) else $error("queue count out of range");

endmodule

>>> hw/rtl/b64c_back.sv
// Back end: expands one group into its results through an output register.
`timescale 1ns / 1ps

module b64c_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  b64c_pkg::job_type q_data,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output b64c_pkg::rsp_type rsp_payload
);
   import b64c_pkg::*;

   job_type    job_ff, job_in;
   logic       job_valid_ff, job_valid_in;
   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;

   logic       adv;
   logic       fin;
   rsp_type    result;
   logic [5:0] sx;
   logic [7:0] byte_sel;

   assign adv   = job_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign fin   = adv && (idx_ff == job_ff.cnt_m1);
   assign q_pop = q_valid && (!job_valid_ff || fin);

   always_comb begin
      case (idx_ff)
         2'd0:    sx = job_ff.bits[23:18];
         2'd1:    sx = job_ff.bits[17:12];
         2'd2:    sx = job_ff.bits[11:6];
         default: sx = job_ff.bits[5:0];
      endcase
      case (idx_ff)
         2'd0:    byte_sel = job_ff.bits[23:16];
         2'd1:    byte_sel = job_ff.bits[15:8];
         default: byte_sel = job_ff.bits[7:0];
      endcase
   end

   always_comb begin
      result.out_last  = job_ff.last && (idx_ff == job_ff.cnt_m1);
      result.bad_input = job_ff.bad;
      if (job_ff.mode == MODE_ENCODE) begin
         result.out_byte = (idx_ff <= job_ff.enc_cnt) ? sextet_char(sx) : PAD_CHAR;
      end else begin
         result.out_byte = byte_sel;
      end
   end

   always_comb begin
      job_in       = q_pop ? q_data : job_ff;
      job_valid_in = q_pop ? 1'b1 : (fin ? 1'b0 : job_valid_ff);
      idx_in       = (q_pop || fin) ? 2'd0 : (adv ? idx_ff + 2'd1 : idx_ff);
      rsp_valid_in = adv ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
      rsp_in       = adv ? result : rsp_ff;
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff |-> idx_ff <= job_ff.cnt_m1) else $error("result index past group");
   a_enc_four: assert property (@(posedge clock) disable iff (reset)
      (job_valid_ff && job_ff.mode == MODE_ENCODE) |-> job_ff.cnt_m1 == 2'd3)
      else $error("encode group not four characters");
   a_dec_three: assert property (@(posedge clock) disable iff (reset)
      (job_valid_ff && job_ff.mode == MODE_DECODE) |-> job_ff.cnt_m1 != 2'd3)
      else $error("decode group over three bytes");

endmodule

>>> hw/rtl/base64_stream_codec.sv
// Top level of the streaming base64 encoder/decoder.
`timescale 1ns / 1ps

// Usage
//   req_*: one byte (encode) or character (decode) per transfer, in_last
//   closes a stream. rsp_*: one character or byte per transfer.
//   csr_we/csr_wdata: mode, 0 = encode, 1 = decode. Write only while idle;
//   a write drops any partial group.
// Structure
//   Front assembles groups and pushes one entry per finished group into a
//   QUEUE_DEPTH deep queue; back expands each entry into 1..4 results, one
//   per cycle while rsp_stall is low, through a registered output.
// Result path / throughput
//   First result of a completed group passes the queue, the back end's job
//   register and the output register before it is valid.
//   The back end emits one result per cycle while rsp_stall is low; encode
//   is bound by the output channel (4 chars per 3 bytes), decode by the
//   input at one character per cycle.
// Reset / stall
//   Synchronous reset clears mode to encode, the group state, queue and
//   output. When rsp_stall holds, the output register keeps its transfer;
//   the queue fills and req_stall rises once it is full.
module base64_stream_codec #(
   parameter int QUEUE_DEPTH = b64c_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic              csr_wdata,
   input  logic              req_valid,
   output logic              req_stall,
   input  b64c_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output b64c_pkg::rsp_type rsp_payload
);
   import b64c_pkg::*;

   logic    q_full;
   logic    q_push;
   job_type q_wdata;
   logic    q_pop;
   logic    q_valid;
   job_type q_rdata;

   b64c_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (q_wdata)
   );

   b64c_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .q_valid   (q_valid),
      .pop_data  (q_rdata)
   );

   b64c_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_data      (q_rdata),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> tb/base64_stream_codec_tb.sv
// Self-checking testbench: base64_stream_codec encode/decode streams vs. a behavioral predictor.
`timescale 1ns / 1ps

module base64_stream_codec_tb;
   import b64c_pkg::*;

   localparam int LATENCY_CYCLES = 8;    // closing input to last result, with margin
   localparam int IDLE_LIMIT     = 2000; // cycles without any transfer before giving up
   localparam int GAP_MAX        = 11;
   localparam int PHASE_ITEMS    = 18;   // minimum random items per random phase
   localparam int LONG_HOLD      = 80;   // receiver hold-off that backs up the queue
   localparam int MAX_REPORTS    = 10;

   // Expected-output tracker with its own copy of the codec state.
   class b64_scoreboard;
      logic        mode;
      int unsigned grp_cnt;
      logic [23:0] grp_bits;
      logic        third_pad;
      logic        grp_bad;
      rsp_type     due_out[$];
      int unsigned fail_cnt;

      function new();
         mode     = MODE_ENCODE;
         fail_cnt = 0;
         clear_group();
      endfunction

      static function logic [7:0] symbol_of(logic [5:0] s);
         string abc = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
         return abc[s];
      endfunction

      // -1 for anything outside the alphabet (pad included)
      static function int sextet_of(logic [7:0] c);
         for (int i = 0; i < 64; i++) begin
            if (symbol_of(6'(i)) == c) return i;
         end
         return -1;
      endfunction

      function void clear_group();
         grp_cnt   = 0;
         grp_bits  = '0;
         third_pad = 1'b0;
         grp_bad   = 1'b0;
      endfunction

      function void set_mode(logic m);
         mode = m;
         clear_group();
      endfunction

      function void push_out(logic [7:0] b, logic last, logic bad);
         rsp_type r;
         r.out_byte  = b;
         r.out_last  = last;
         r.bad_input = bad;
         due_out.push_back(r);
      endfunction

      function void encode_byte(logic [7:0] b, logic last);
         grp_bits = grp_bits | (24'(b) << (16 - 8 * grp_cnt));
         grp_cnt++;
         if (grp_cnt < 3 && !last) return;
         // grp_cnt + 1 characters carry data, the rest are pad
         for (int k = 0; k < 4; k++) begin
            push_out((k <= grp_cnt) ? symbol_of(6'(grp_bits >> (18 - 6 * k))) : PAD_CHAR,
                     last && k == 3, 1'b0);
         end
         clear_group();
      endfunction

      function void decode_char(logic [7:0] c, logic last);
         int unsigned pos;
         int          v;
         int          n;
         logic        pad;
         logic [5:0]  s;
         pos = grp_cnt;
         pad = (c == PAD_CHAR);
         s   = '0;
         if (!pad) begin
            v = sextet_of(c);
            if (v < 0) grp_bad = 1'b1;
            else s = 6'(v);
         end
         if (pos == 2) third_pad = pad;
         grp_bits = grp_bits | (24'(s) << (18 - 6 * pos));
         if (pos < 3) begin
            grp_cnt = pos + 1;
            if (!last) return;
            // stream ended off a group boundary: single error result
            push_out(8'h00, 1'b1, 1'b1);
            clear_group();
            return;
         end
         n = 3;
         if (last) begin
            if (pad) n--;
            if (third_pad) n--;
         end
         for (int k = 0; k < n; k++) begin
            push_out(8'(grp_bits >> (16 - 8 * k)), last && k == n - 1, grp_bad);
         end
         clear_group();
      endfunction

      function void note_request(req_type r);
         if (mode == MODE_ENCODE) encode_byte(r.in_byte, r.in_last);
         else decode_char(r.in_byte, r.in_last);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (due_out.size() == 0) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
               $display("unexpected result: byte %02h last %0b bad %0b",
                        got.out_byte, got.out_last, got.bad_input);
            return;
         end
         want = due_out.pop_front();
         if (want.out_byte != got.out_byte || want.out_last != got.out_last ||
             want.bad_input != got.bad_input) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
               $display("mismatch: expected byte %02h last %0b bad %0b, got byte %02h last %0b bad %0b",
                        want.out_byte, want.out_last, want.bad_input,
                        got.out_byte, got.out_last, got.bad_input);
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    csr_we = 1'b0;
   logic    csr_wdata = 1'b0;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b1;
   rsp_type rsp_payload;

   b64_scoreboard sb = new();

   int tx_calm = 0;        // sender items left in a no-gap run
   int rx_calm = 0;        // receiver results left in a no-gap run
   int rx_hold_cycles = 0; // one-shot long hold-off requested by the stimulus
   int idle_cycles = 0;
   int sent_items = 0;

   base64_stream_codec u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Gap before the next transfer, 0..GAP_MAX; now and then a run of back-to-back
   // transfers so that the fully loaded case is covered as well.
   function automatic int draw_gap(inout int calm);
      if (calm == 0 && $urandom_range(0, 7) == 0) calm = $urandom_range(8, 24);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      return $urandom_range(0, GAP_MAX);
   endfunction

   // Watchdog: any cycle without a transfer on either channel counts toward the limit.
   initial begin
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
               $display("CHECK FAILED");
               $finish;
            end
         end
      end
   end

   // Receiver: random stall before each result, one long hold-off on request.
   // Signals are sampled right after the edge, so they hold pre-edge values.
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         gap = draw_gap(rx_calm);
         if (rx_hold_cycles > 0) begin
            gap = rx_hold_cycles;
            rx_hold_cycles = 0;
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         sb.check_response(rsp_payload);
      end
   end

   // One input transfer; the predictor sees it at the edge where it is taken.
   task automatic send_item(logic [7:0] b, logic last);
      int gap;
      gap = draw_gap(tx_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_payload.in_byte <= b;
      req_payload.in_last <= last;
      req_valid           <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(req_payload);
      sent_items++;
   endtask

   // Characters of s in order, last marked on the final one.
   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], i == s.len() - 1);
   endtask

   task automatic wait_drained();
      while (sb.due_out.size() != 0) @(posedge clock);
   endtask

   // Mode change only with the block idle: all results in, plus time for a
   // partial group (which yields nothing) to settle inside the block.
   task automatic write_mode(logic m);
      req_valid <= 1'b0;
      wait_drained();
      repeat (LATENCY_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_mode(m);
   endtask

   task automatic send_enc_stream(logic close);
      int len;
      len = $urandom_range(1, 9);
      for (int i = 0; i < len; i++)
         send_item(8'($urandom_range(0, 255)), close && i == len - 1);
   endtask

   // Mostly well-formed text with random content; some noise characters,
   // stray pads and ragged lengths mixed in.
   task automatic send_dec_stream(logic close);
      logic [7:0] chars[$];
      logic [7:0] c;
      int         groups;
      int         npad;
      groups = $urandom_range(1, 3);
      for (int g = 0; g < groups; g++) begin
         for (int p = 0; p < 4; p++) begin
            c = b64_scoreboard::symbol_of(6'($urandom_range(0, 63)));
            if ($urandom_range(0, 11) == 0) c = 8'($urandom_range(0, 255));
            else if ($urandom_range(0, 19) == 0) c = PAD_CHAR;
            chars.push_back(c);
         end
      end
      npad = $urandom_range(0, 2);
      if (npad > 0) chars[chars.size() - 1] = PAD_CHAR;
      if (npad > 1) chars[chars.size() - 2] = PAD_CHAR;
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(1, 3)) void'(chars.pop_back());
      end
      for (int i = 0; i < chars.size(); i++)
         send_item(chars[i], close && i == chars.size() - 1);
   endtask

   // Random streams until the phase quota is met; the final stream is sometimes
   // left open so the following mode write has a partial group to drop.
   task automatic random_phase(logic m, logic pause_mid);
      int start;
      logic paused;
      start  = sent_items;
      paused = 1'b0;
      while (sent_items - start < PHASE_ITEMS) begin
         if (pause_mid && !paused && sent_items - start >= PHASE_ITEMS / 2) begin
            // sender waits for every outstanding result before going on
            req_valid <= 1'b0;
            wait_drained();
            @(posedge clock);
            paused = 1'b1;
         end
         if (m == MODE_ENCODE)
            send_enc_stream(sent_items - start < PHASE_ITEMS - 6 || $urandom_range(0, 2) != 0);
         else
            send_dec_stream(sent_items - start < PHASE_ITEMS - 8 || $urandom_range(0, 2) != 0);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed encode ----
      write_mode(MODE_ENCODE);
      send_item(8'h00, 1'b1);                 // one byte: two pads
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b1);                 // two bytes: one pad
      send_item(8'hFB, 1'b0);                 // "+///": top of the alphabet
      send_item(8'hFF, 1'b0);
      send_item(8'hFF, 1'b1);
      send_item(8'h4D, 1'b0);                 // full group, then a closing partial one
      send_item(8'h61, 1'b0);
      send_item(8'h6E, 1'b0);
      send_item(8'h01, 1'b1);

      // ---- directed decode ----
      write_mode(MODE_DECODE);
      send_item("+", 1'b0);                   // pad inside the stream counts as zero
      send_item("/", 1'b0);
      send_item("A", 1'b0);
      send_item(PAD_CHAR, 1'b0);
      send_text("TQ==");                      // two pads drop two bytes
      send_item(8'hFF, 1'b0);                 // bad characters, pad only in third slot
      send_item("*", 1'b0);
      send_item(PAD_CHAR, 1'b0);
      send_item("A", 1'b1);
      send_item(8'h00, 1'b0);                 // length error
      send_item("z", 1'b1);

      // ---- random phases, alternating mode ----
      write_mode(MODE_ENCODE);
      rx_hold_cycles = LONG_HOLD;             // back up the queue until input stalls
      random_phase(MODE_ENCODE, 1'b0);
      write_mode(MODE_DECODE);
      random_phase(MODE_DECODE, 1'b1);
      write_mode(MODE_ENCODE);
      random_phase(MODE_ENCODE, 1'b1);
      write_mode(MODE_DECODE);
      random_phase(MODE_DECODE, 1'b0);

      req_valid <= 1'b0;
      wait_drained();
      repeat (LATENCY_CYCLES) @(posedge clock);
      if (sb.due_out.size() != 0) sb.fail_cnt += sb.due_out.size();
      if (sb.fail_cnt == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
